[rtl/core/lcs_pkg.sv]
// Shared constants, types and state encoding for the LCS block.
`default_nettype none
package lcs_pkg;
    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_TB_RD,
        ST_TB_DEC,
        ST_EMPTY,
        ST_FINISH
    } lcs_state_t;
endpackage
`default_nettype wire

[rtl/core/longest_common_subsequence.sv]
// Top level: string loading, systolic score fill, traceback and result output.
// Loads one byte per cycle (s_tready is high while idle). After the final byte of the
// second string a row of MAX_LEN column cells computes the score table wavefront
// style: the first string's bytes shift through the row, one per cycle. Each
// traceback step is then a registered read of the cell column memories and the
// first-string memory (ST_TB_RD) followed by a decision (ST_TB_DEC), at most
// n1 + n2 steps in all; a step stalls only while the output register is full.
// Bytes past MAX_LEN in either string are dropped and flagged as truncated.
`default_nettype none
module longest_common_subsequence #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic [1:0]  s_tuser,   // [0] mode, [1] has_symbol
    input  wire logic        s_tlast,   // last_of_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] lcs_symbol, [14:8] lcs_length, [15] zero
    output logic [1:0]       m_tuser,   // [0] empty_res, [1] truncated
    output logic             m_tlast    // last_of_result
);
    import lcs_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    lcs_state_t state_reg, state_next;

    logic [CW-1:0] n1_reg, n1_next, n2_reg, n2_next;
    logic          cut_reg, cut_next;
    logic [CW-1:0] feed_reg, feed_next;
    logic          feed_valid_reg;
    logic [AW-1:0] feed_row_reg;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] tb_i_reg, tb_i_next, tb_j_reg, tb_j_next, tb_k_reg, tb_k_next;

    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] out_sym_reg, out_sym_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    logic             out_empty_reg, out_empty_next;
    logic             out_trunc_reg, out_trunc_next;
    logic             out_last_reg, out_last_next;

    logic [SYM_W-1:0] fst_mem [MAX_LEN];
    logic [SYM_W-1:0] fst_rd_reg;
    logic [AW-1:0]    fst_rd_addr;
    logic             s_acc, fst_wr, sec_wr, slot_free;

    logic             lk_valid [MAX_LEN+1];
    logic [SYM_W-1:0] lk_sym   [MAX_LEN+1];
    logic [AW-1:0]    lk_row   [MAX_LEN+1];
    logic [CW-1:0]    lk_score [MAX_LEN+1];
    logic [SYM_W-1:0] sec_sym  [MAX_LEN];
    logic [CW-1:0]    col_rd   [MAX_LEN];
    logic [CW-1:0]    right_rd [MAX_LEN];
    logic [AW-1:0]    cell_addr [MAX_LEN];

    logic [CW-1:0] below, right, ni, nj, nk;
    logic          match;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign fst_wr    = s_acc && s_tuser[1] && !s_tuser[0] && (n1_reg < CW'(MAX_LEN));
    assign sec_wr    = s_acc && s_tuser[1] && s_tuser[0] && (n2_reg < CW'(MAX_LEN));

    assign fst_rd_addr = (state_reg == ST_FILL) ? AW'(n1_reg - feed_reg - CW'(1))
                                                : AW'(tb_i_reg);

    always_ff @(posedge aclk) begin
        if (fst_wr) begin
            fst_mem[AW'(n1_reg)] <= s_tdata;
        end
        fst_rd_reg <= fst_mem[fst_rd_addr];
    end

    // top of the row sees the right-hand boundary column
    assign lk_valid[MAX_LEN] = feed_valid_reg;
    assign lk_sym[MAX_LEN]   = fst_rd_reg;
    assign lk_row[MAX_LEN]   = feed_row_reg;
    assign lk_score[MAX_LEN] = '0;

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        assign cell_addr[k] = (tb_j_reg == CW'(k)) ? AW'(tb_i_reg + CW'(1)) : AW'(tb_i_reg);
        if (k + 1 < MAX_LEN) begin : g_rt
            assign right_rd[k] = col_rd[k+1];
        end else begin : g_rt_end
            assign right_rd[k] = '0;
        end
        lcs_cell #(.MAX_LEN(MAX_LEN), .IDX(k), .CW(CW), .AW(AW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (state_reg == ST_IDLE),
            .ld_en     (sec_wr),
            .ld_idx    (n2_reg),
            .ld_sym    (s_tdata),
            .n2        (n2_reg),
            .in_valid  (lk_valid[k+1]),
            .in_sym    (lk_sym[k+1]),
            .in_row    (lk_row[k+1]),
            .in_score  (lk_score[k+1]),
            .out_valid (lk_valid[k]),
            .out_sym   (lk_sym[k]),
            .out_row   (lk_row[k]),
            .out_score (lk_score[k]),
            .col_sym   (sec_sym[k]),
            .rd_addr   (cell_addr[k]),
            .rd_data   (col_rd[k])
        );
    end

    always_comb begin
        match = (fst_rd_reg == sec_sym[AW'(tb_j_reg)]);
        below = (tb_i_reg + CW'(1) == n1_reg) ? '0 : col_rd[AW'(tb_j_reg)];
        right = (tb_j_reg + CW'(1) == n2_reg) ? '0 : right_rd[AW'(tb_j_reg)];
        ni = tb_i_reg;
        nj = tb_j_reg;
        nk = tb_k_reg;
        if (match) begin
            ni = tb_i_reg + CW'(1);
            nj = tb_j_reg + CW'(1);
            nk = tb_k_reg + CW'(1);
        end else if (below >= right) begin
            ni = tb_i_reg + CW'(1);
        end else begin
            nj = tb_j_reg + CW'(1);
        end
    end

    always_comb begin
        state_next     = state_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        cut_next       = cut_reg;
        feed_next      = feed_reg;
        len_next       = len_reg;
        tb_i_next      = tb_i_reg;
        tb_j_next      = tb_j_reg;
        tb_k_next      = tb_k_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_sym_next   = out_sym_reg;
        out_len_next   = out_len_reg;
        out_empty_next = out_empty_reg;
        out_trunc_next = out_trunc_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                feed_next = '0;
                if (s_acc) begin
                    if (fst_wr) n1_next = n1_reg + CW'(1);
                    if (sec_wr) n2_next = n2_reg + CW'(1);
                    if (s_tuser[1] && !fst_wr && !sec_wr) cut_next = 1'b1;
                    if (s_tuser[0] && s_tlast) begin
                        if (n1_reg == '0 || n2_next == '0) state_next = ST_EMPTY;
                        else                                state_next = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                if (feed_reg < n1_reg) feed_next = feed_reg + CW'(1);
                if (lk_valid[0] && lk_row[0] == '0) begin
                    len_next  = lk_score[0];
                    tb_i_next = '0;
                    tb_j_next = '0;
                    tb_k_next = '0;
                    state_next = (lk_score[0] == '0) ? ST_EMPTY : ST_TB_RD;
                end
            end
            ST_TB_RD: begin
                state_next = ST_TB_DEC;
            end
            ST_TB_DEC: begin
                if (!match || slot_free) begin
                    if (match) begin
                        out_valid_next = 1'b1;
                        out_sym_next   = fst_rd_reg;
                        out_len_next   = LEN_W'(len_reg);
                        out_empty_next = 1'b0;
                        out_trunc_next = cut_reg;
                        out_last_next  = (nk == len_reg);
                    end
                    tb_i_next = ni;
                    tb_j_next = nj;
                    tb_k_next = nk;
                    if (ni < n1_reg && nj < n2_reg && nk < len_reg) state_next = ST_TB_RD;
                    else                                            state_next = ST_FINISH;
                end
            end
            ST_EMPTY: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_sym_next   = '0;
                    out_len_next   = '0;
                    out_empty_next = 1'b1;
                    out_trunc_next = cut_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n1_next    = '0;
                n2_next    = '0;
                cut_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            n1_reg         <= '0;
            n2_reg         <= '0;
            cut_reg        <= 1'b0;
            feed_reg       <= '0;
            feed_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            tb_k_reg       <= '0;
            len_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            n1_reg         <= n1_next;
            n2_reg         <= n2_next;
            cut_reg        <= cut_next;
            feed_reg       <= feed_next;
            feed_valid_reg <= (state_reg == ST_FILL) && (feed_reg < n1_reg);
            out_valid_reg  <= out_valid_next;
            tb_k_reg       <= tb_k_next;
            len_reg        <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        feed_row_reg  <= fst_rd_addr;
        tb_i_reg      <= tb_i_next;
        tb_j_reg      <= tb_j_next;
        out_sym_reg   <= out_sym_next;
        out_len_reg   <= out_len_next;
        out_empty_reg <= out_empty_next;
        out_trunc_reg <= out_trunc_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_len_reg, out_sym_reg};
    assign m_tuser  = {out_trunc_reg, out_empty_reg};
    assign m_tlast  = out_last_reg;

    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        n1_reg <= CW'(MAX_LEN) && n2_reg <= CW'(MAX_LEN))
        else $error("string count past capacity");

    a_tb_k_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TB_DEC) |-> tb_k_reg < len_reg)
        else $error("traceback emitted more than the score");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && m_tdata[14:8] == 7'd0))
        else $error("empty result must be single and zero length");

    a_no_load_during_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> !s_tready)
        else $error("input taken during fill");
endmodule
`default_nettype wire

[rtl/core/lcs_cell.sv]
// One column cell: holds a second-string byte, computes its column of scores, stores them.
`default_nettype none
module lcs_cell #(
    parameter int MAX_LEN = lcs_pkg::MAX_LEN_DEF,
    parameter int IDX     = 0,
    parameter int CW      = $clog2(MAX_LEN + 1),
    parameter int AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     clear,
    input  wire logic                     ld_en,
    input  wire logic [CW-1:0]            ld_idx,
    input  wire logic [lcs_pkg::SYM_W-1:0] ld_sym,
    input  wire logic [CW-1:0]            n2,
    input  wire logic                     in_valid,
    input  wire logic [lcs_pkg::SYM_W-1:0] in_sym,
    input  wire logic [AW-1:0]            in_row,
    input  wire logic [CW-1:0]            in_score,
    output logic                          out_valid,
    output logic [lcs_pkg::SYM_W-1:0]     out_sym,
    output logic [AW-1:0]                 out_row,
    output logic [CW-1:0]                 out_score,
    output logic [lcs_pkg::SYM_W-1:0]     col_sym,
    input  wire logic [AW-1:0]            rd_addr,
    output logic [CW-1:0]                 rd_data
);
    import lcs_pkg::*;

    logic [SYM_W-1:0] b_reg;
    logic [CW-1:0]    below_reg, diag_reg;
    logic             valid_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [AW-1:0]    row_reg;
    logic [CW-1:0]    score_reg;
    logic [CW-1:0]    score_next;
    logic             col_on;
    logic [CW-1:0]    col_mem [MAX_LEN];
    logic [CW-1:0]    rd_reg;

    assign col_on = (CW'(IDX) < n2);

    always_comb begin
        if (!col_on) begin
            score_next = '0;
        end else if (in_sym == b_reg) begin
            score_next = diag_reg + CW'(1);
        end else if (below_reg >= in_score) begin
            score_next = below_reg;
        end else begin
            score_next = in_score;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_en && ld_idx == CW'(IDX)) begin
            b_reg <= ld_sym;
        end
        if (clear) begin
            below_reg <= '0;
            diag_reg  <= '0;
        end else if (in_valid) begin
            below_reg <= score_next;
            diag_reg  <= in_score;
            sym_reg   <= in_sym;
            row_reg   <= in_row;
            score_reg <= score_next;
        end
    end

    // score column, one entry per row of the first string
    always_ff @(posedge aclk) begin
        if (in_valid) begin
            col_mem[in_row] <= score_next;
        end
        rd_reg <= col_mem[rd_addr];
    end

    assign out_valid = valid_reg;
    assign out_sym   = sym_reg;
    assign out_row   = row_reg;
    assign out_score = score_reg;
    assign col_sym   = b_reg;
    assign rd_data   = rd_reg;
endmodule
`default_nettype wire

[dv/tb.sv]
// Testbench for the longest common subsequence block: directed and random string pairs.
`timescale 1ns / 100ps
module tb;
    localparam int MAXL = lcs_pkg::MAX_LEN_DEF;

    typedef struct packed {
        logic [7:0] sym;
        logic [6:0] len;
        logic       empty;
        logic       trunc;
        logic       last;
    } lcs_out_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = 0;
    logic [1:0]  s_tuser = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    longest_common_subsequence dut (.*);

    initial forever #1 aclk = ~aclk;

    // predictor state
    logic [7:0] str_a [MAXL];
    logic [7:0] str_b [MAXL];
    int         cnt_a, cnt_b;
    logic       cut;
    lcs_out_t   lcs_expected [$];
    int         n_fail = 0;
    int         n_items = 0;
    int         n_runs = 0;
    int         n_results = 0;
    bit         calm = 0;

    function automatic void predict_lcs(bit mode, logic [7:0] sym, bit has, bit lst);
        int score [MAXL + 1][MAXL + 1];
        int i, j, k, len;
        lcs_out_t r;
        if (has) begin
            if (!mode) begin
                if (cnt_a < MAXL) begin str_a[cnt_a] = sym; cnt_a++; end
                else cut = 1;
            end else begin
                if (cnt_b < MAXL) begin str_b[cnt_b] = sym; cnt_b++; end
                else cut = 1;
            end
        end
        if (!(mode && lst)) return;
        for (i = cnt_a; i >= 0; i--)
            for (j = cnt_b; j >= 0; j--)
                if (i == cnt_a || j == cnt_b) score[i][j] = 0;
                else if (str_a[i] == str_b[j]) score[i][j] = 1 + score[i+1][j+1];
                else score[i][j] = (score[i+1][j] > score[i][j+1]) ?
                                   score[i+1][j] : score[i][j+1];
        len = (cnt_a && cnt_b) ? score[0][0] : 0;
        if (len == 0) begin
            r = '{sym: 0, len: 0, empty: 1, trunc: cut, last: 1};
            lcs_expected.push_back(r);
        end else begin
            i = 0; j = 0; k = 0;
            while (i < cnt_a && j < cnt_b && k < len) begin
                if (str_a[i] == str_b[j]) begin
                    r = '{sym: str_a[i], len: len[6:0], empty: 0, trunc: cut,
                          last: (k + 1 == len)};
                    lcs_expected.push_back(r);
                    k++; i++; j++;
                end else if (score[i+1][j] >= score[i][j+1]) i++;
                else j++;
            end
        end
        cnt_a = 0; cnt_b = 0; cut = 0; n_runs++;
    endfunction

    task automatic send_item(bit mode, logic [7:0] sym, bit has, bit lst);
        while (!calm && $urandom_range(99) < 11) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= sym;
        s_tuser  <= {has, mode};
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_lcs(mode, sym, has, lst);
        n_items++;
    endtask

    task automatic send_string(bit mode, int n, int alpha);
        if (n == 0) send_item(mode, 8'($urandom), 0, 1);
        else for (int i = 0; i < n; i++)
            send_item(mode, 8'($urandom_range(alpha - 1)), 1, i == n - 1);
    endtask

    always @(posedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
    end

    // result checker
    always @(posedge aclk) begin
        lcs_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (lcs_expected.size() == 0) begin
                $error("result item with no expectation waiting");
                n_fail++;
            end else begin
                e = lcs_expected.pop_front();
                if (m_tdata[7:0] !== e.sym) begin
                    $error("lcs_symbol exp %0h got %0h", e.sym, m_tdata[7:0]); n_fail++;
                end
                if (m_tdata[14:8] !== e.len) begin
                    $error("lcs_length exp %0d got %0d", e.len, m_tdata[14:8]); n_fail++;
                end
                if (m_tuser[0] !== e.empty) begin
                    $error("empty_res exp %0b got %0b", e.empty, m_tuser[0]); n_fail++;
                end
                if (m_tuser[1] !== e.trunc) begin
                    $error("truncated exp %0b got %0b", e.trunc, m_tuser[1]); n_fail++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_of_result exp %0b got %0b", e.last, m_tlast); n_fail++;
                end
            end
        end
    end

    task automatic test_empty_cases();
        send_string(0, 0, 2); send_string(1, 0, 2);
        send_string(0, 3, 4); send_string(1, 0, 2);
        send_string(0, 0, 2); send_string(1, 3, 4);
        send_item(0, 8'h41, 1, 1); send_item(1, 8'h42, 1, 1);   // no common char
    endtask

    task automatic test_extremes();
        send_item(0, 8'h00, 1, 0); send_item(0, 8'hff, 1, 0); send_item(0, 8'h01, 1, 1);
        send_item(0, 8'h80, 1, 0);                 // late first-string byte
        send_item(0, 8'h00, 0, 0);                 // no symbol, no effect
        send_item(1, 8'h80, 1, 0); send_item(1, 8'hff, 1, 0);
        send_item(1, 8'h00, 1, 0); send_item(1, 8'h55, 0, 1);
    endtask

    task automatic test_overflow();
        send_string(0, MAXL + 2, 3); send_string(1, 4, 3);
        send_string(0, 3, 2);        send_string(1, MAXL + 1, 2);
    endtask

    task automatic test_random(int budget);
        int start, pick;
        start = n_items;
        while (n_items - start < budget) begin
            pick = $urandom_range(9);
            if (pick == 0)
                send_item(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else begin
                send_string(0, (pick == 1) ? $urandom_range(MAXL) : $urandom_range(8),
                            $urandom_range(1) ? 4 : 256);
                send_string(1, $urandom_range(8), $urandom_range(1) ? 4 : 256);
            end
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_tvalid <= 0;
        while (lcs_expected.size() != 0 && guard < 200000) begin
            @(posedge aclk); guard++;
        end
        repeat (300) @(posedge aclk);
    endtask

    initial begin
        cnt_a = 0; cnt_b = 0; cut = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_empty_cases();
        test_extremes();
        test_overflow();
        test_random(50);
        calm = 1;
        test_random(30);
        calm = 0;
        test_random(30);
        drain();
        if (lcs_expected.size() != 0) begin
            $error("%0d expected results never arrived", lcs_expected.size());
            n_fail++;
        end
        $display("Sent %0d items in %0d string pairs, checked %0d result items.",
                 n_items, n_runs, n_results);
        if (n_fail == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule

[sim.f]
rtl/core/lcs_pkg.sv
rtl/core/lcs_cell.sv
rtl/core/longest_common_subsequence.sv
dv/tb.sv
